// ===== rtl/core/amc_pkg.sv =====
package amc_pkg;

    // Format codes, shared by the extension class, the sniffed format and the plan.
    localparam int FMT_W = 4;
    typedef logic [FMT_W-1:0] t_fmt;
    localparam t_fmt FMT_NONE   = 4'd0;
    localparam t_fmt FMT_ZIP    = 4'd1;
    localparam t_fmt FMT_7Z     = 4'd2;
    localparam t_fmt FMT_RAR    = 4'd3;
    localparam t_fmt FMT_TAR    = 4'd4;
    localparam t_fmt FMT_GZIP   = 4'd5;
    localparam t_fmt FMT_BZIP2  = 4'd6;
    localparam t_fmt FMT_XZ     = 4'd7;
    localparam t_fmt FMT_ZSTD   = 4'd8;
    localparam t_fmt FMT_LZ4    = 4'd9;
    localparam t_fmt FMT_BROTLI = 4'd10;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NONE      = 2'd0;
    localparam t_kind KIND_CONTAINER = 2'd1;
    localparam t_kind KIND_STREAM    = 2'd2;

    typedef logic [2:0] t_filt;
    localparam t_filt FILT_NONE   = 3'd0;
    localparam t_filt FILT_BROTLI = 3'd6;

    // A stream format sits this far above its filter code.
    localparam t_fmt FILT_TO_FMT = 4'd4;

    typedef logic [1:0] t_backend;
    localparam t_backend BE_NONE    = 2'd0;
    localparam t_backend BE_GENERAL = 2'd1;
    localparam t_backend BE_ALT_LIB = 2'd2;
    localparam t_backend BE_BROTLI  = 2'd3;

    typedef logic [7:0] t_byte;

    // Leading signatures in priority order, padded to the longest mark.
    localparam int NUM_LEAD  = 10;
    localparam int SIG_MAX   = 6;
    localparam int USTAR_BIT = 10;
    localparam int USTAR_AT  = 257;
    localparam int USTAR_LEN = 5;
    localparam int ALIVE_W   = NUM_LEAD + 1;

    localparam t_byte LEAD_SIG [NUM_LEAD][SIG_MAX] = '{
        '{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C},
        '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h05, 8'h06, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h07, 8'h08, 8'h00, 8'h00},
        '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07},
        '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h5A, 8'h68, 8'h00, 8'h00, 8'h00},
        '{8'hFD, 8'h37, 8'h7A, 8'h58, 8'h5A, 8'h00},
        '{8'h28, 8'hB5, 8'h2F, 8'hFD, 8'h00, 8'h00},
        '{8'h04, 8'h22, 8'h4D, 8'h18, 8'h00, 8'h00}
    };
    localparam logic [2:0] LEAD_LEN [NUM_LEAD] = '{
        3'd6, 3'd4, 3'd4, 3'd4, 3'd6, 3'd2, 3'd3, 3'd6, 3'd4, 3'd4
    };
    localparam t_fmt LEAD_FMT [NUM_LEAD] = '{
        FMT_7Z, FMT_ZIP, FMT_ZIP, FMT_ZIP, FMT_RAR,
        FMT_GZIP, FMT_BZIP2, FMT_XZ, FMT_ZSTD, FMT_LZ4
    };
    localparam t_byte USTAR_SIG [USTAR_LEN] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};

    typedef struct packed {
        logic  matched;
        t_fmt  format;
        t_kind kind;
        t_filt filter;
    } t_ext_class;

    typedef struct packed {
        t_fmt     format;
        t_kind    kind;
        t_filt    filter;
        t_backend backend;
        logic     overridden;
    } t_plan;

endpackage

// ===== rtl/core/amc_sniffer.sv =====
module amc_sniffer import amc_pkg::*; #(
    parameter int HEADER_BYTES = 512
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_byte i_header_byte,
    input  logic  i_byte_present,
    input  logic  i_last_item,
    output t_fmt  o_sniffed
);

    localparam int CW = $clog2(HEADER_BYTES + 1);

    logic [CW-1:0]      r_count, n_count;
    logic [ALIVE_W-1:0] r_alive, n_alive;
    logic [CW-1:0]      ustar_off;
    logic               take_byte;

    always_comb begin
        n_count   = r_count;
        n_alive   = r_alive;
        ustar_off = r_count - CW'(USTAR_AT);
        take_byte = i_take && i_byte_present && (r_count < CW'(HEADER_BYTES));
        if (take_byte) begin
            for (int i = 0; i < NUM_LEAD; i++) begin
                if (r_count < CW'(LEAD_LEN[i]) &&
                    i_header_byte != LEAD_SIG[i][r_count[2:0]]) begin
                    n_alive[i] = 1'b0;
                end
            end
            if (r_count >= CW'(USTAR_AT) && r_count < CW'(USTAR_AT + USTAR_LEN) &&
                i_header_byte != USTAR_SIG[ustar_off[2:0]]) begin
                n_alive[USTAR_BIT] = 1'b0;
            end
            n_count = r_count + 1'b1;
        end
    end

    // The result is judged on the state as it stands after this word's byte.
    always_comb begin
        o_sniffed = FMT_NONE;
        if (n_alive[USTAR_BIT] && n_count >= CW'(USTAR_AT + USTAR_LEN)) begin
            o_sniffed = FMT_TAR;
        end
        for (int i = NUM_LEAD - 1; i >= 0; i--) begin
            if (n_alive[i] && n_count >= CW'(LEAD_LEN[i])) begin
                o_sniffed = LEAD_FMT[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_alive <= '1;
        end else if (i_take) begin
            if (i_last_item) begin
                r_count <= '0;
                r_alive <= '1;
            end else begin
                r_count <= n_count;
                r_alive <= n_alive;
            end
        end
    end

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HEADER_BYTES))
        else $error("byte count ran past the header size");

    a_fresh_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last_item) |=> (r_count == '0 && r_alive == '1))
        else $error("state not cleared after the last word of a header");

    a_ustar_untouched : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(USTAR_AT)) |-> r_alive[USTAR_BIT])
        else $error("tar mark dropped before its offset was reached");

endmodule

// ===== rtl/core/amc_planner.sv =====
module amc_planner import amc_pkg::*; (
    input  t_fmt       i_sniffed,
    input  t_ext_class i_ext,
    output t_plan      o_plan
);

    t_fmt  ef;
    t_kind ek;
    t_filt efl;
    logic  brotli_ext;
    logic  agrees;

    always_comb begin
        // Codes outside their range count as unknown.
        ef  = (i_ext.format > FMT_BROTLI) ? FMT_NONE : i_ext.format;
        ek  = (i_ext.kind > KIND_STREAM) ? KIND_NONE : i_ext.kind;
        efl = (i_ext.filter > FILT_BROTLI) ? FILT_NONE : i_ext.filter;

        brotli_ext = i_ext.matched && (ef == FMT_BROTLI || efl == FILT_BROTLI);
        agrees = i_ext.matched && (i_sniffed == ef ||
                 (efl != FILT_NONE && i_sniffed == FMT_W'(efl) + FILT_TO_FMT));

        o_plan = '0;
        if (brotli_ext || (i_sniffed != FMT_NONE && agrees) ||
            (i_sniffed == FMT_NONE && i_ext.matched)) begin
            o_plan.format = ef;
            o_plan.kind   = ek;
            o_plan.filter = efl;
        end else if (i_sniffed != FMT_NONE) begin
            o_plan.format     = i_sniffed;
            o_plan.kind       = (i_sniffed <= FMT_TAR) ? KIND_CONTAINER : KIND_STREAM;
            o_plan.filter     = (i_sniffed >= FMT_GZIP) ?
                                3'(i_sniffed - FILT_TO_FMT) : FILT_NONE;
            o_plan.overridden = i_ext.matched;
        end

        if (o_plan.format == FMT_NONE) begin
            o_plan.backend = BE_NONE;
        end else if (o_plan.filter == FILT_BROTLI || o_plan.format == FMT_BROTLI) begin
            o_plan.backend = BE_BROTLI;
        end else if (o_plan.format == FMT_RAR) begin
            o_plan.backend = BE_ALT_LIB;
        end else begin
            o_plan.backend = BE_GENERAL;
        end
    end

endmodule

// ===== rtl/core/archive_magic_classifier.sv =====
// Archive format classifier. Feed the header bytes of a file one word per byte,
// in file order, and mark the final word with i_last_item; that word also carries
// the class derived from the file name's extension, and it may be an empty word
// (i_byte_present low) that only closes the header. The block tracks ten leading
// signatures (7z, three zip marks, rar, gzip, bzip2, xz, zstd, lz4) and the tar
// mark "ustar" at offset 257, chooses the first live signature in that priority
// order with tar last, reconciles it with the extension class and names a backend.
// Only the final word of a header yields a result word; the others yield nothing.
// Bytes beyond HEADER_BYTES are ignored and the count holds there. One word can be
// taken every clock cycle: each byte only updates a position counter and a row of
// match flags, and the final word's result is formed in the same cycle and held in
// the output register, so it appears on the cycle after the word is taken. While a
// result sits unread in that register, o_ready follows i_ready, so every word, not
// only a final one, waits until the consumer takes the result; a result read in the
// same cycle lets the next word in at once, and the block is ready for a new header
// straight after a final word.
module archive_magic_classifier import amc_pkg::*; #(
    parameter int HEADER_BYTES = 512
) (
    input  logic     i_clk,
    input  logic     i_rst_n,

    input  logic     i_valid,
    output logic     o_ready,
    input  t_byte    i_header_byte,
    input  logic     i_byte_present,
    input  logic     i_last_item,
    input  logic     i_ext_matched,
    input  t_fmt     i_ext_format,
    input  t_kind    i_ext_kind,
    input  t_filt    i_ext_filter,

    output logic     o_valid,
    input  logic     i_ready,
    output t_fmt     o_sniffed_format,
    output t_fmt     o_plan_format,
    output t_kind    o_plan_kind,
    output t_filt    o_plan_filter,
    output t_backend o_backend,
    output logic     o_overridden
);

    logic       accept;
    t_fmt       sniffed;
    t_ext_class ext;
    t_plan      plan;

    logic       r_out_valid;
    t_fmt       r_sniffed;
    t_plan      r_plan;

    // A new word may enter whenever the output register is empty or is being read.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign ext = '{matched: i_ext_matched, format: i_ext_format,
                   kind: i_ext_kind, filter: i_ext_filter};

    amc_sniffer #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_sniffer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (accept),
        .i_header_byte  (i_header_byte),
        .i_byte_present (i_byte_present),
        .i_last_item    (i_last_item),
        .o_sniffed      (sniffed)
    );

    amc_planner u_planner (
        .i_sniffed (sniffed),
        .i_ext     (ext),
        .o_plan    (plan)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_last_item) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result payload needs no reset; it is only looked at while valid.
    always_ff @(posedge i_clk) begin
        if (accept && i_last_item) begin
            r_sniffed <= sniffed;
            r_plan    <= plan;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_sniffed_format = r_sniffed;
    assign o_plan_format    = r_plan.format;
    assign o_plan_kind      = r_plan.kind;
    assign o_plan_filter    = r_plan.filter;
    assign o_backend        = r_plan.backend;
    assign o_overridden     = r_plan.overridden;

    a_backend_none : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_plan_format == FMT_NONE) == (o_backend == BE_NONE)))
        else $error("backend disagrees with an empty plan");

    a_override_content : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overridden) |->
        (o_plan_format == o_sniffed_format && o_sniffed_format != FMT_NONE))
        else $error("override flagged without a content plan");

    a_alt_lib_rar : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_backend == BE_ALT_LIB) |-> (o_plan_format == FMT_RAR))
        else $error("alternative library chosen for a format other than rar");

endmodule

// ===== tb/sv/tb_archive_magic_classifier.sv =====
module tb_archive_magic_classifier import amc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_BYTES   = 512;
    localparam int LEAD_COUNT  = 10;
    localparam int TAR_BIT     = LEAD_COUNT;
    localparam int TAR_AT      = 257;
    localparam int TAR_LEN     = 5;

    // Leading marks in priority order, first byte in the top octet, padded with zeros.
    localparam bit [0:LEAD_COUNT-1][47:0] LEAD_MARKS = {
        48'h37_7A_BC_AF_27_1C, 48'h50_4B_03_04_00_00, 48'h50_4B_05_06_00_00,
        48'h50_4B_07_08_00_00, 48'h52_61_72_21_1A_07, 48'h1F_8B_00_00_00_00,
        48'h42_5A_68_00_00_00, 48'hFD_37_7A_58_5A_00, 48'h28_B5_2F_FD_00_00,
        48'h04_22_4D_18_00_00
    };
    localparam bit [0:LEAD_COUNT-1][2:0] LEAD_LENS = {
        3'd6, 3'd4, 3'd4, 3'd4, 3'd6, 3'd2, 3'd3, 3'd6, 3'd4, 3'd4
    };
    localparam bit [0:LEAD_COUNT-1][3:0] LEAD_FMTS = {
        FMT_7Z, FMT_ZIP, FMT_ZIP, FMT_ZIP, FMT_RAR,
        FMT_GZIP, FMT_BZIP2, FMT_XZ, FMT_ZSTD, FMT_LZ4
    };
    localparam bit [39:0] TAR_MARK = 40'h75_73_74_61_72;

    typedef t_byte t_bytes[$];

    typedef struct packed {
        t_fmt  sniffed;
        t_plan plan;
    } t_verdict;

    function automatic t_bytes mark_prefix(int s, int n);
        t_bytes q;
        for (int p = 0; p < n; p++) q = {q, t_byte'(LEAD_MARKS[s][8*(5-p) +: 8])};
        return q;
    endfunction

    // Follows the header as it streams in and keeps the verdicts still owed by the block.
    class verdict_board;
        bit [9:0]              taken;
        bit [LEAD_COUNT:0]     alive;
        t_verdict              awaited_verdicts[$];
        int                    errors;

        function new();
            taken  = '0;
            alive  = '1;
            errors = 0;
        endfunction

        task report(string what);
            $display("%0d ns: mismatch: %s", $time, what);
            errors++;
        endtask

        function void take_byte(t_byte b);
            int k;
            if (taken >= HDR_BYTES) return;
            for (int s = 0; s < LEAD_COUNT; s++) begin
                if (taken < LEAD_LENS[s] &&
                    b != t_byte'(LEAD_MARKS[s][8*(5-int'(taken)) +: 8]))
                    alive[s] = 1'b0;
            end
            k = int'(taken) - TAR_AT;
            if (k >= 0 && k < TAR_LEN && b != t_byte'(TAR_MARK[8*(TAR_LEN-1-k) +: 8]))
                alive[TAR_BIT] = 1'b0;
            taken = taken + 10'd1;
        endfunction

        function t_fmt sniff_content();
            for (int s = 0; s < LEAD_COUNT; s++) begin
                if (alive[s] && taken >= LEAD_LENS[s]) return t_fmt'(LEAD_FMTS[s]);
            end
            if (alive[TAR_BIT] && taken >= TAR_AT + TAR_LEN) return FMT_TAR;
            return FMT_NONE;
        endfunction

        function t_backend pick_backend(t_fmt f, t_filt filt);
            if (f == FMT_NONE) return BE_NONE;
            if (filt == FILT_BROTLI || f == FMT_BROTLI) return BE_BROTLI;
            if (f == FMT_RAR) return BE_ALT_LIB;
            return BE_GENERAL;
        endfunction

        function void note_word(t_byte b, bit present, bit last, bit em,
                                t_fmt ef, t_kind ek, t_filt efl);
            t_verdict v;
            bit       agree;
            if (present) take_byte(b);
            if (!last) return;
            if (ef > FMT_BROTLI) ef = FMT_NONE;
            if (ek > KIND_STREAM) ek = KIND_NONE;
            if (efl > FILT_BROTLI) efl = FILT_NONE;
            v = '0;
            v.sniffed = sniff_content();
            agree = em && (v.sniffed == ef ||
                           (efl != FILT_NONE && v.sniffed == t_fmt'(efl) + FILT_TO_FMT));
            if ((em && (ef == FMT_BROTLI || efl == FILT_BROTLI)) ||
                (v.sniffed == FMT_NONE && em) || (v.sniffed != FMT_NONE && agree)) begin
                v.plan.format = ef;
                v.plan.kind   = ek;
                v.plan.filter = efl;
            end else if (v.sniffed != FMT_NONE) begin
                v.plan.format     = v.sniffed;
                v.plan.kind       = (v.sniffed <= FMT_TAR) ? KIND_CONTAINER : KIND_STREAM;
                v.plan.filter     = (v.sniffed >= FMT_GZIP) ?
                                    t_filt'(v.sniffed - FILT_TO_FMT) : FILT_NONE;
                v.plan.overridden = em;
            end
            v.plan.backend = pick_backend(v.plan.format, v.plan.filter);
            awaited_verdicts = {awaited_verdicts, v};
            taken = '0;
            alive = '1;
        endfunction

        task check_verdict(t_verdict got);
            t_verdict want;
            if (awaited_verdicts.size() == 0) begin
                report($sformatf("result word %h with nothing outstanding", got));
                return;
            end
            want = awaited_verdicts.pop_front();
            if (got.sniffed !== want.sniffed)
                report($sformatf("sniffed_format %0d, wanted %0d",
                                 got.sniffed, want.sniffed));
            if (got.plan.format !== want.plan.format)
                report($sformatf("plan_format %0d, wanted %0d",
                                 got.plan.format, want.plan.format));
            if (got.plan.kind !== want.plan.kind)
                report($sformatf("plan_kind %0d, wanted %0d",
                                 got.plan.kind, want.plan.kind));
            if (got.plan.filter !== want.plan.filter)
                report($sformatf("plan_filter %0d, wanted %0d",
                                 got.plan.filter, want.plan.filter));
            if (got.plan.backend !== want.plan.backend)
                report($sformatf("backend %0d, wanted %0d",
                                 got.plan.backend, want.plan.backend));
            if (got.plan.overridden !== want.plan.overridden)
                report($sformatf("overridden %0d, wanted %0d",
                                 got.plan.overridden, want.plan.overridden));
        endtask
    endclass

    logic     i_clk          = 1'b0;
    logic     i_rst_n        = 1'b0;
    logic     i_valid        = 1'b0;
    logic     o_ready;
    t_byte    i_header_byte  = '0;
    logic     i_byte_present = 1'b0;
    logic     i_last_item    = 1'b0;
    logic     i_ext_matched  = 1'b0;
    t_fmt     i_ext_format   = FMT_NONE;
    t_kind    i_ext_kind     = KIND_NONE;
    t_filt    i_ext_filter   = FILT_NONE;
    logic     o_valid;
    logic     i_ready        = 1'b0;
    t_fmt     o_sniffed_format;
    t_fmt     o_plan_format;
    t_kind    o_plan_kind;
    t_filt    o_plan_filter;
    t_backend o_backend;
    logic     o_overridden;

    verdict_board verdicts = new();

    // When steady is set neither side inserts gaps, so runs of back-to-back words occur.
    bit     steady       = 1'b0;
    int     stall_left   = 0;
    int     words_sent   = 0;
    int     headers_sent = 0;
    t_bytes no_bytes;

    archive_magic_classifier #(.HEADER_BYTES(HDR_BYTES)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_header_byte    (i_header_byte),
        .i_byte_present   (i_byte_present),
        .i_last_item      (i_last_item),
        .i_ext_matched    (i_ext_matched),
        .i_ext_format     (i_ext_format),
        .i_ext_kind       (i_ext_kind),
        .i_ext_filter     (i_ext_filter),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sniffed_format (o_sniffed_format),
        .o_plan_format    (o_plan_format),
        .o_plan_kind      (o_plan_kind),
        .o_plan_filter    (o_plan_filter),
        .o_backend        (o_backend),
        .o_overridden     (o_overridden)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Offers one word, holding it steady until the block takes it. The handshake is
    // sampled at the rising edge, so what is seen here is the value before the edge.
    task automatic send_word(input t_byte b, input bit present, input bit last,
                             input bit em, input t_fmt ef, input t_kind ek, input t_filt efl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_header_byte  <= b;
        i_byte_present <= present;
        i_last_item    <= last;
        i_ext_matched  <= em;
        i_ext_format   <= ef;
        i_ext_kind     <= ek;
        i_ext_filter   <= efl;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        verdicts.note_word(b, present, last, em, ef, ek, efl);
        words_sent++;
    endtask

    // Sends a whole header. The extension class rides on every byte word and on the closing
    // word, but only the final word counts; an empty word with a random class is slipped in
    // now and then, and an empty word closes the header when asked to or when there are no bytes.
    task automatic send_header(input t_bytes hdr, input bit close_empty, input bit em,
                               input t_fmt ef, input t_kind ek, input t_filt efl);
        for (int k = 0; k < hdr.size(); k++) begin
            if ($urandom_range(0, 19) == 0)
                send_word(t_byte'($urandom), 1'b0, 1'b0, 1'($urandom), t_fmt'($urandom),
                          t_kind'($urandom), t_filt'($urandom));
            send_word(hdr[k], 1'b1, !close_empty && k == hdr.size() - 1, em, ef, ek, efl);
        end
        if (close_empty || hdr.size() == 0)
            send_word(t_byte'($urandom), 1'b0, 1'b1, em, ef, ek, efl);
        headers_sent++;
    endtask

    // A header long enough to reach the tar mark, sometimes behind a leading mark.
    // Beyond HDR_BYTES the bytes must be ignored, which the longest one checks.
    task automatic send_long(input int n, input bit spoil_tar);
        t_bytes hdr;
        int     s;
        s = int'($urandom_range(0, 29));
        if (s < LEAD_COUNT) hdr = mark_prefix(s, int'(LEAD_LENS[s]));
        while (hdr.size() < n) hdr = {hdr, t_byte'($urandom)};
        for (int k = 0; k < TAR_LEN; k++) begin
            if (TAR_AT + k < n) hdr[TAR_AT + k] = t_byte'(TAR_MARK[8*(TAR_LEN-1-k) +: 8]);
        end
        if (spoil_tar) begin
            s = TAR_AT + int'($urandom_range(0, TAR_LEN - 1));
            hdr[s] = hdr[s] ^ t_byte'($urandom_range(1, 255));
        end
        send_header(hdr, 1'($urandom), 1'($urandom), t_fmt'($urandom), t_kind'($urandom),
                    t_filt'($urandom));
    endtask

    // A short header: most carry a leading mark, now and then cut short or with one
    // byte spoilt, followed by random bytes; the rest are plain random bytes. The
    // extension class often agrees with the mark, directly or through its filter.
    task automatic send_short();
        t_bytes hdr;
        t_fmt   hint;
        int     s;
        int     r;
        int     n;
        bit     em;
        t_fmt   ef;
        t_kind  ek;
        t_filt  efl;
        hint = FMT_NONE;
        r = int'($urandom_range(0, 99));
        if (r < 70) begin
            s    = int'($urandom_range(0, LEAD_COUNT - 1));
            hint = t_fmt'(LEAD_FMTS[s]);
            hdr  = mark_prefix(s, int'(LEAD_LENS[s]));
            r    = int'($urandom_range(0, 9));
            if (r == 0) begin
                hdr = mark_prefix(s, int'($urandom_range(0, int'(LEAD_LENS[s]) - 1)));
            end else if (r == 1) begin
                n = int'($urandom_range(0, hdr.size() - 1));
                hdr[n] = hdr[n] ^ t_byte'($urandom_range(1, 255));
            end
            n = int'($urandom_range(0, 6));
        end else begin
            n = int'($urandom_range(0, 10));
        end
        repeat (n) hdr = {hdr, t_byte'($urandom)};

        r = int'($urandom_range(0, 99));
        if (hint != FMT_NONE && r < 45) begin
            em = 1'b1;
            if (hint >= FMT_GZIP && r < 15) begin
                ef  = FMT_TAR;
                ek  = KIND_CONTAINER;
                efl = t_filt'(hint - FILT_TO_FMT);
            end else begin
                ef  = hint;
                ek  = (hint <= FMT_TAR) ? KIND_CONTAINER : KIND_STREAM;
                efl = (hint >= FMT_GZIP) ? t_filt'(hint - FILT_TO_FMT) : FILT_NONE;
            end
        end else begin
            em  = 1'($urandom);
            ef  = t_fmt'($urandom);
            ek  = t_kind'($urandom);
            efl = t_filt'($urandom);
        end
        send_header(hdr, hdr.size() == 0 || $urandom_range(0, 3) == 0, em, ef, ek, efl);
    endtask

    // Result side: check every word taken, then decide whether to stall for a while.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                verdicts.check_verdict(t_verdict'({o_sniffed_format, o_plan_format,
                                                   o_plan_kind, o_plan_filter,
                                                   o_backend, o_overridden}));
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed headers: agreement, an override after an empty closing word, an
        // empty header with and without an extension, brotli from the extension alone,
        // rar to its own library, out-of-range extension codes, agreement through the
        // filter, and a mark cut short.
        send_header(mark_prefix(0, 6), 1'b0, 1'b1, FMT_7Z, KIND_CONTAINER, FILT_NONE);
        send_header(mark_prefix(5, 2), 1'b1, 1'b1, FMT_ZIP, KIND_CONTAINER, FILT_NONE);
        send_header(no_bytes, 1'b1, 1'b0, FMT_NONE, KIND_NONE, FILT_NONE);
        send_header(no_bytes, 1'b1, 1'b1, FMT_BROTLI, KIND_STREAM, FILT_BROTLI);
        send_header(mark_prefix(4, 6), 1'b0, 1'b0, FMT_ZSTD, KIND_STREAM, FILT_NONE);
        send_header({8'hFF}, 1'b0, 1'b1, '1, '1, '1);
        send_header(mark_prefix(7, 6), 1'b0, 1'b1, FMT_TAR, KIND_CONTAINER,
                    t_filt'(FMT_XZ - FILT_TO_FMT));
        send_header(mark_prefix(6, 2), 1'b0, 1'b1, FMT_BZIP2, KIND_STREAM,
                    t_filt'(FMT_BZIP2 - FILT_TO_FMT));

        // The long headers come next: one past the header size with a tar mark, one
        // just long enough whose mark may be spoilt, and one a byte too short.
        send_long(HDR_BYTES + 3, 1'b0);
        send_long(TAR_AT + TAR_LEN, 1'($urandom));
        send_long(TAR_AT + TAR_LEN - 1, 1'b0);

        while (words_sent < 1350 || headers_sent < 60) begin
            if (headers_sent % 8 == 0) steady = ($urandom_range(0, 4) == 0);
            send_short();
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        // A result appears in the cycle after its last word is taken; give it a little margin.
        while (verdicts.awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (verdicts.errors == 0)
            $display("archive_magic_classifier regression: pass");
        else
            $display("archive_magic_classifier regression: fail");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("archive_magic_classifier regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/amc_pkg.sv
rtl/core/amc_sniffer.sv
rtl/core/amc_planner.sv
rtl/core/archive_magic_classifier.sv
tb/sv/tb_archive_magic_classifier.sv
